### hw/rtl/pcaa_pkg.sv
// Package for the per-channel autocorrelation accumulator.
// Field widths, register codes and the command/status types shared by
// the controller, the datapath and the top level. No dependencies.
package pcaa_pkg;

   // input word fields
   localparam int CH_IN_W  = 10;
   localparam int GAIN_W   = 3;
   localparam int SMP_IN_W = 12;
   localparam int REQ_W    = 32;

   // result word fields
   localparam int OPOS_W   = 5;
   localparam int SUM_W    = 28;
   localparam int LAG_W    = 45;
   localparam int CNT_W    = 16;
   localparam int RSP_W    = 112;

   // configuration
   localparam int TPS_W     = 16;
   localparam int SPD_W     = 6;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;
   localparam logic REG_TPS = 1'b0;
   localparam logic REG_SPD = 1'b1;
   localparam logic [TPS_W-1:0] TPS_RESET = 16'd100;
   localparam logic [SPD_W-1:0] SPD_RESET = 6'd5;

   // gain codes at or above this are invalid
   localparam logic [GAIN_W-1:0] GAIN_LIMIT = 3'd3;

   // controller to datapath commands
   typedef struct packed {
      logic buf_we;     // store incoming sample in digit buffer
      logic cap;        // capture channel and gain of incoming word
      logic mod_step;   // reduce the captured channel modulo CHANNELS
      logic cnt_clr;    // clear one trigger count entry (reset sweep)
      logic cnt_rd;     // read trigger count of the channel
      logic cnt_wr;     // write updated trigger count
      logic sum_rd;     // read sums at current lag
      logic acc_clr;    // clear lag product accumulator
      logic mac_issue;  // issue one product read pair
      logic mac_first;  // first pair of a lag (carries s[lag])
      logic wb;         // write back sums at current lag
      logic zero_wr;    // zero sums at current lag
      logic out_load;   // load a normal result word
      logic out_last;   // final word of the run
      logic out_err;    // load an error result word
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic in_bad;     // incoming gain is invalid
      logic first;      // this trigger is the first of the channel's step
      logic emit;       // count reached the step
      logic out_free;   // output register can take a word
   } status_type;

endpackage

### hw/rtl/pcaa_ctrl.sv
// Controller for the autocorrelation accumulator: sequences the reset count sweep, digit capture,
// channel reduction, count update, the per-lag multiply loop and emission of result or error words.
// Depends on pcaa_pkg.
module pcaa_ctrl #(
   parameter int CHANNELS    = 1024,
   parameter int MAX_SAMPLES = 32,
   parameter int POS_W       = 5,
   parameter int NCNT_W      = 6,
   parameter int CH_W        = 10
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [pcaa_pkg::SPD_W-1:0]  spd,
   input  pcaa_pkg::status_type        status,
   output pcaa_pkg::cmd_type           cmd,
   output logic [POS_W-1:0]            buf_waddr,
   output logic [POS_W-1:0]            rd_a,
   output logic [POS_W-1:0]            rd_b,
   output logic [POS_W-1:0]            lag,
   output logic [CH_W-1:0]             clr_idx
);

   localparam logic [3:0] ST_CLR     = 4'd0;
   localparam logic [3:0] ST_IDLE    = 4'd1;
   localparam logic [3:0] ST_MOD     = 4'd2;
   localparam logic [3:0] ST_CNT_RD  = 4'd3;
   localparam logic [3:0] ST_CNT_WR  = 4'd4;
   localparam logic [3:0] ST_LAG     = 4'd5;
   localparam logic [3:0] ST_MAC     = 4'd6;
   localparam logic [3:0] ST_DRAIN   = 4'd7;
   localparam logic [3:0] ST_WB      = 4'd8;
   localparam logic [3:0] ST_EMIT_RD = 4'd9;
   localparam logic [3:0] ST_EMIT    = 4'd10;
   localparam logic [3:0] ST_ERR     = 4'd11;

   localparam logic [CH_W-1:0]  CLR_LAST = CH_W'(CHANNELS - 1);
   localparam logic [POS_W-1:0] LAG_LAST = POS_W'(MAX_SAMPLES - 1);

   logic [3:0]               state_ff, state_in;
   logic [POS_W-1:0]         pos_ff, pos_in;
   logic                     bad_ff, bad_in;
   logic                     err_ff, err_in;
   logic [POS_W-1:0]         lag_ff, lag_in;
   logic [POS_W-1:0]         j_ff, j_in;
   logic [1:0]               d_ff, d_in;
   logic [CH_W-1:0]          clr_ff, clr_in;

   logic [NCNT_W-1:0] n_eff;
   logic [POS_W-1:0]  pos_eff;
   logic              bad_now;
   logic              lag_live;

   // effective samples per digit: zero acts as one, saturate at the maximum
   always_comb begin
      if (spd == '0) begin
         n_eff = NCNT_W'(1);
      end else if (32'(spd) > 32'(MAX_SAMPLES)) begin
         n_eff = NCNT_W'(MAX_SAMPLES);
      end else begin
         n_eff = NCNT_W'(spd);
      end
   end

   assign pos_eff  = (NCNT_W'(pos_ff) >= n_eff) ? POS_W'(n_eff - 1'b1) : pos_ff;
   assign bad_now  = bad_ff | status.in_bad;
   assign lag_live = NCNT_W'(lag_ff) < n_eff;

   assign req_tready = (state_ff == ST_IDLE);
   assign buf_waddr  = pos_eff;
   assign rd_a       = j_ff;
   assign rd_b       = POS_W'(j_ff + lag_ff);
   assign lag        = lag_ff;
   assign clr_idx    = clr_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      bad_in   = bad_ff;
      err_in   = err_ff;
      lag_in   = lag_ff;
      j_in     = j_ff;
      d_in     = d_ff;
      clr_in   = clr_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLR: begin
            cmd.cnt_clr = 1'b1;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == CLR_LAST) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.buf_we = 1'b1;
               cmd.cap    = 1'b1;
               if (NCNT_W'(pos_eff) + 1'b1 < n_eff) begin
                  pos_in = pos_eff + 1'b1;
                  bad_in = bad_now;
               end else begin
                  pos_in   = '0;
                  bad_in   = 1'b0;
                  err_in   = bad_now;
                  state_in = ST_MOD;
               end
            end
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            state_in     = err_ff ? ST_ERR : ST_CNT_RD;
         end
         ST_CNT_RD: begin
            cmd.cnt_rd = 1'b1;
            state_in   = ST_CNT_WR;
         end
         ST_CNT_WR: begin
            cmd.cnt_wr = 1'b1;
            lag_in     = '0;
            state_in   = ST_LAG;
         end
         ST_LAG: begin
            if (lag_live) begin
               cmd.sum_rd  = 1'b1;
               cmd.acc_clr = 1'b1;
               j_in        = '0;
               state_in    = ST_MAC;
            end else begin
               // positions past the digit restart at a first trigger
               cmd.zero_wr = status.first;
               if (lag_ff == LAG_LAST) begin
                  lag_in   = '0;
                  state_in = status.emit ? ST_EMIT_RD : ST_IDLE;
               end else begin
                  lag_in = lag_ff + 1'b1;
               end
            end
         end
         ST_MAC: begin
            cmd.mac_issue = 1'b1;
            cmd.mac_first = (j_ff == '0);
            if (NCNT_W'(j_ff) + NCNT_W'(lag_ff) == n_eff - 1'b1) begin
               d_in     = '0;
               state_in = ST_DRAIN;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            d_in = d_ff + 1'b1;
            if (d_ff == 2'd2) begin
               state_in = ST_WB;
            end
         end
         ST_WB: begin
            cmd.wb = 1'b1;
            if (lag_ff == LAG_LAST) begin
               lag_in   = '0;
               state_in = status.emit ? ST_EMIT_RD : ST_IDLE;
            end else begin
               lag_in   = lag_ff + 1'b1;
               state_in = ST_LAG;
            end
         end
         ST_EMIT_RD: begin
            cmd.sum_rd = 1'b1;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = (NCNT_W'(lag_ff) + 1'b1 == n_eff);
               if (cmd.out_last) begin
                  state_in = ST_IDLE;
               end else begin
                  lag_in   = lag_ff + 1'b1;
                  state_in = ST_EMIT_RD;
               end
            end
         end
         ST_ERR: begin
            if (status.out_free) begin
               cmd.out_err = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
         pos_ff   <= '0;
         bad_ff   <= 1'b0;
         err_ff   <= 1'b0;
         lag_ff   <= '0;
         j_ff     <= '0;
         d_ff     <= '0;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         bad_ff   <= bad_in;
         err_ff   <= err_in;
         lag_ff   <= lag_in;
         j_ff     <= j_in;
         d_ff     <= d_in;
         clr_ff   <= clr_in;
      end
   end

endmodule

### hw/rtl/pcaa_dp.sv
// Datapath for the autocorrelation accumulator: digit buffer, trigger
// count and sum memories, shared multiplier, accumulator, output register.
// Depends on pcaa_pkg.
module pcaa_dp #(
   parameter int CHANNELS    = 1024,
   parameter int MAX_SAMPLES = 32,
   parameter int SAMPLE_BITS = 12,
   parameter int POS_W       = 5,
   parameter int CH_W        = 10,
   parameter int ADDR_W      = 15
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [pcaa_pkg::CH_IN_W-1:0]  in_channel,
   input  logic [pcaa_pkg::GAIN_W-1:0]   in_gain,
   input  logic [pcaa_pkg::SMP_IN_W-1:0] in_sample,
   input  logic [pcaa_pkg::TPS_W-1:0]    tps,
   input  pcaa_pkg::cmd_type             cmd,
   output pcaa_pkg::status_type          status,
   input  logic [POS_W-1:0]              buf_waddr,
   input  logic [POS_W-1:0]              rd_a,
   input  logic [POS_W-1:0]              rd_b,
   input  logic [POS_W-1:0]              lag,
   input  logic [CH_W-1:0]               clr_idx,
   input  logic                          rsp_tready,
   output logic                          rsp_valid,
   output logic [pcaa_pkg::CH_IN_W-1:0]  rsp_channel,
   output logic [pcaa_pkg::GAIN_W-1:0]   rsp_gain,
   output logic [pcaa_pkg::OPOS_W-1:0]   rsp_position,
   output logic [pcaa_pkg::SUM_W-1:0]    rsp_sample_sum,
   output logic [pcaa_pkg::LAG_W-1:0]    rsp_lag_sum,
   output logic [pcaa_pkg::CNT_W-1:0]    rsp_total,
   output logic                          rsp_last,
   output logic                          rsp_bad
);

   localparam int PROD_W = 2 * SAMPLE_BITS;

   // reciprocal of CHANNELS, exact for every channel code of the input
   localparam int     RECIP_SH  = pcaa_pkg::CH_IN_W + $clog2(CHANNELS);
   localparam int     RECIP_W   = pcaa_pkg::CH_IN_W + 2;
   localparam int     QP_W      = pcaa_pkg::CH_IN_W + RECIP_W;
   localparam longint RECIP_NUM = longint'(1) << RECIP_SH;
   localparam logic [RECIP_W-1:0] RECIP_M =
      RECIP_W'((RECIP_NUM + longint'(CHANNELS) - 1) / longint'(CHANNELS));

   // memories
   logic [SAMPLE_BITS-1:0]       buf_mem [MAX_SAMPLES];
   logic [pcaa_pkg::CNT_W-1:0]   cnt_mem [CHANNELS];
   logic [pcaa_pkg::SUM_W-1:0]   sum_mem [CHANNELS*MAX_SAMPLES];
   logic [pcaa_pkg::LAG_W-1:0]   lag_mem [CHANNELS*MAX_SAMPLES];

   logic [pcaa_pkg::CH_IN_W-1:0] chan_ff, chan_in;
   logic [pcaa_pkg::GAIN_W-1:0]  gain_ff;
   logic [SAMPLE_BITS-1:0]       a_ff, b_ff, bl_ff;
   logic                         v1_ff, f1_ff, v2_ff;
   logic [PROD_W-1:0]            prod_ff;
   logic [pcaa_pkg::LAG_W-1:0]   acc_ff;
   logic [pcaa_pkg::CNT_W-1:0]   cq_ff;
   logic [pcaa_pkg::SUM_W-1:0]   sq_ff;
   logic [pcaa_pkg::LAG_W-1:0]   lq_ff;
   logic                         first_ff, emit_ff;
   logic [pcaa_pkg::CNT_W-1:0]   total_ff;
   logic                         out_valid_ff;

   logic [CH_W-1:0]              cnt_addr;
   logic [ADDR_W-1:0]            sum_addr;
   logic [pcaa_pkg::CNT_W-1:0]   cnt_new;
   logic [pcaa_pkg::TPS_W-1:0]   tps_eff;
   logic                         reach;
   logic [QP_W-1:0]              q_prod;
   logic [pcaa_pkg::CH_IN_W-1:0] quot;
   logic [31:0]                  q_back;

   // channel reduction: quotient by reciprocal multiply, then subtract
   always_comb begin
      q_prod  = QP_W'(chan_ff) * QP_W'(RECIP_M);
      quot    = pcaa_pkg::CH_IN_W'(q_prod >> RECIP_SH);
      q_back  = 32'(quot) * 32'(CHANNELS);
      chan_in = chan_ff;
      if (cmd.cap) begin
         chan_in = in_channel;
      end else if (cmd.mod_step) begin
         chan_in = chan_ff - pcaa_pkg::CH_IN_W'(q_back);
      end
   end

   assign cnt_addr = cmd.cnt_clr ? clr_idx : CH_W'(chan_ff);
   assign sum_addr = ADDR_W'(32'(chan_ff) * 32'(MAX_SAMPLES) + 32'(lag));
   assign cnt_new  = cq_ff + 1'b1;
   assign tps_eff  = (tps == '0) ? pcaa_pkg::TPS_W'(1) : tps;
   assign reach    = cnt_new >= tps_eff;

   assign status.in_bad   = in_gain >= pcaa_pkg::GAIN_LIMIT;
   assign status.first    = first_ff;
   assign status.emit     = emit_ff;
   assign status.out_free = !out_valid_ff || rsp_tready;

   // digit buffer, two registered read ports
   always_ff @(posedge clock) begin
      if (cmd.buf_we) begin
         buf_mem[buf_waddr] <= SAMPLE_BITS'(in_sample);
      end
      a_ff <= buf_mem[rd_a];
      b_ff <= buf_mem[rd_b];
   end

   // trigger counts
   always_ff @(posedge clock) begin
      if (cmd.cnt_clr) begin
         cnt_mem[cnt_addr] <= '0;
      end else if (cmd.cnt_wr) begin
         cnt_mem[cnt_addr] <= reach ? '0 : cnt_new;
      end
      if (cmd.cnt_rd) begin
         cq_ff <= cnt_mem[cnt_addr];
      end
   end

   // position and lag sums
   always_ff @(posedge clock) begin
      if (cmd.zero_wr) begin
         sum_mem[sum_addr] <= '0;
         lag_mem[sum_addr] <= '0;
      end else if (cmd.wb) begin
         sum_mem[sum_addr] <= (first_ff ? '0 : sq_ff) + pcaa_pkg::SUM_W'(bl_ff);
         lag_mem[sum_addr] <= (first_ff ? '0 : lq_ff) + acc_ff;
      end
      if (cmd.sum_rd) begin
         sq_ff <= sum_mem[sum_addr];
         lq_ff <= lag_mem[sum_addr];
      end
   end

   // multiply-accumulate pipeline and digit bookkeeping
   always_ff @(posedge clock) begin
      chan_ff <= chan_in;
      if (cmd.cap) begin
         gain_ff <= in_gain;
      end
      prod_ff <= PROD_W'(a_ff * b_ff);
      if (f1_ff) begin
         bl_ff <= b_ff;
      end
      if (cmd.acc_clr) begin
         acc_ff <= '0;
      end else if (v2_ff) begin
         acc_ff <= acc_ff + pcaa_pkg::LAG_W'(prod_ff);
      end
      if (cmd.cnt_wr) begin
         first_ff <= (cnt_new == pcaa_pkg::CNT_W'(1));
         emit_ff  <= reach;
         total_ff <= cnt_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         f1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.mac_issue;
         f1_ff <= cmd.mac_issue & cmd.mac_first;
         v2_ff <= v1_ff;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load || cmd.out_err) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load || cmd.out_err) begin
         rsp_channel <= chan_ff;
         rsp_gain    <= gain_ff;
         rsp_last    <= cmd.out_last | cmd.out_err;
         rsp_bad     <= cmd.out_err;
      end
      if (cmd.out_load) begin
         rsp_position   <= pcaa_pkg::OPOS_W'(lag);
         rsp_sample_sum <= sq_ff;
         rsp_lag_sum    <= lq_ff;
         rsp_total      <= total_ff;
      end else if (cmd.out_err) begin
         rsp_position   <= '0;
         rsp_sample_sum <= '0;
         rsp_lag_sum    <= '0;
         rsp_total      <= '0;
      end
   end

   assign rsp_valid = out_valid_ff;

endmodule

### hw/rtl/per_channel_autocorrelation_accumulator_top.sv
// Top level of the per-channel autocorrelation accumulator: stream ports,
// register port, controller and datapath. Depends on pcaa_pkg, pcaa_ctrl
// and pcaa_dp.
//
// Accumulates per-channel sample sums and lag products over a step of
// triggers, one sample word per input, and emits one word per sample
// position when a channel's step completes. After reset a sweep clears
// the trigger counts; no word is taken meanwhile. A sample that does
// not end a digit leaves the block ready for the next sample. A sample
// that ends a digit starts the channel reduction, count update and the
// multiply loop, set by the single multiplier walking every lag's product
// pairs, then emission when the step completes, stalled by the sink. No
// sample is taken meanwhile. A bad gain digit emits one error word instead.
module per_channel_autocorrelation_accumulator_top #(
   parameter int CHANNELS    = 1024,
   parameter int MAX_SAMPLES = 32,
   parameter int SAMPLE_BITS = 12
) (
   input  logic                              clock,
   input  logic                              reset,
   // channel[9:0], gain[12:10], sample[24:13]
   input  logic [pcaa_pkg::REQ_W-1:0]        req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // out_channel[9:0], out_gain[12:10], position[17:13], sample_sum[45:18],
   // lag_sum[90:46], trigger_total[106:91]
   output logic [pcaa_pkg::RSP_W-1:0]        rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic                              rsp_tlast,
   // bad_gain[0]
   output logic                              rsp_tuser,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [pcaa_pkg::CSR_AW-1:0]       csr_paddr,
   input  logic [pcaa_pkg::CSR_DW-1:0]       csr_pwdata,
   output logic [pcaa_pkg::CSR_DW-1:0]       csr_prdata,
   output logic                              csr_pready
);

   localparam int POS_W  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
   localparam int NCNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int ADDR_W = (CHANNELS * MAX_SAMPLES > 1) ?
                           $clog2(CHANNELS * MAX_SAMPLES) : 1;

   logic [pcaa_pkg::TPS_W-1:0] tps_ff;
   logic [pcaa_pkg::SPD_W-1:0] spd_ff;
   logic                       csr_wr;

   pcaa_pkg::cmd_type          cmd;
   pcaa_pkg::status_type       status;
   logic [POS_W-1:0]           buf_waddr, rd_a, rd_b, lag;
   logic [CH_W-1:0]            clr_idx;

   logic [pcaa_pkg::CH_IN_W-1:0] o_channel;
   logic [pcaa_pkg::GAIN_W-1:0]  o_gain;
   logic [pcaa_pkg::OPOS_W-1:0]  o_position;
   logic [pcaa_pkg::SUM_W-1:0]   o_sum;
   logic [pcaa_pkg::LAG_W-1:0]   o_lag;
   logic [pcaa_pkg::CNT_W-1:0]   o_total;

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff <= pcaa_pkg::TPS_RESET;
         spd_ff <= pcaa_pkg::SPD_RESET;
      end else if (csr_wr) begin
         unique case (csr_paddr[2])
            pcaa_pkg::REG_TPS: tps_ff <= csr_pwdata[pcaa_pkg::TPS_W-1:0];
            pcaa_pkg::REG_SPD: spd_ff <= csr_pwdata[pcaa_pkg::SPD_W-1:0];
            default:           tps_ff <= tps_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         pcaa_pkg::REG_TPS: csr_prdata = pcaa_pkg::CSR_DW'(tps_ff);
         pcaa_pkg::REG_SPD: csr_prdata = pcaa_pkg::CSR_DW'(spd_ff);
         default:           csr_prdata = '0;
      endcase
   end

   pcaa_ctrl #(
      .CHANNELS    (CHANNELS),
      .MAX_SAMPLES (MAX_SAMPLES),
      .POS_W       (POS_W),
      .NCNT_W      (NCNT_W),
      .CH_W        (CH_W)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .spd        (spd_ff),
      .status     (status),
      .cmd        (cmd),
      .buf_waddr  (buf_waddr),
      .rd_a       (rd_a),
      .rd_b       (rd_b),
      .lag        (lag),
      .clr_idx    (clr_idx)
   );

   pcaa_dp #(
      .CHANNELS    (CHANNELS),
      .MAX_SAMPLES (MAX_SAMPLES),
      .SAMPLE_BITS (SAMPLE_BITS),
      .POS_W       (POS_W),
      .CH_W        (CH_W),
      .ADDR_W      (ADDR_W)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .in_channel     (req_tdata[9:0]),
      .in_gain        (req_tdata[12:10]),
      .in_sample      (req_tdata[24:13]),
      .tps            (tps_ff),
      .cmd            (cmd),
      .status         (status),
      .buf_waddr      (buf_waddr),
      .rd_a           (rd_a),
      .rd_b           (rd_b),
      .lag            (lag),
      .clr_idx        (clr_idx),
      .rsp_tready     (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .rsp_channel    (o_channel),
      .rsp_gain       (o_gain),
      .rsp_position   (o_position),
      .rsp_sample_sum (o_sum),
      .rsp_lag_sum    (o_lag),
      .rsp_total      (o_total),
      .rsp_last       (rsp_tlast),
      .rsp_bad        (rsp_tuser)
   );

   assign rsp_tdata = {5'b0, o_total, o_lag, o_sum, o_position, o_gain, o_channel};

   // an error word is always the end of its run
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("error word without last");

   // an error word carries no position, sums or count
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[106:13] == '0)
      else $error("error word with payload");

   // a normal word reports a nonzero trigger count
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[106:91] != '0)
      else $error("result word with zero trigger count");

endmodule

### dv/tb.sv
// Self-checking testbench for per_channel_autocorrelation_accumulator_top.
// Depends on pcaa_pkg and the top level; predicts every result word and
// checks it against the stream output under random idling on both sides.
module tb;

   localparam int NCH  = 1024;
   localparam int MAXS = 32;
   localparam int LIMIT = 3000000;

   // register indexes
   localparam int IDX_TPS = 0;
   localparam int IDX_SPD = 1;

   typedef struct packed {
      logic [9:0]                 chan;
      logic [2:0]                 gain;
      logic [4:0]                 pos;
      logic [pcaa_pkg::SUM_W-1:0] ssum;
      logic [pcaa_pkg::LAG_W-1:0] lsum;
      logic [pcaa_pkg::CNT_W-1:0] total;
      logic                       last;
      logic                       bad;
   } result_word_type;

   logic clock = 0;
   logic reset = 1;
   logic [pcaa_pkg::REQ_W-1:0] req_tdata = '0;
   logic req_tvalid = 0;
   logic req_tready;
   logic [pcaa_pkg::RSP_W-1:0] rsp_tdata;
   logic rsp_tvalid, rsp_tlast, rsp_tuser;
   logic rsp_tready = 0;
   logic csr_psel = 0, csr_penable = 0, csr_pwrite = 0;
   logic [pcaa_pkg::CSR_AW-1:0] csr_paddr = '0;
   logic [pcaa_pkg::CSR_DW-1:0] csr_pwdata = '0;
   logic [pcaa_pkg::CSR_DW-1:0] csr_prdata;
   logic csr_pready;

   per_channel_autocorrelation_accumulator_top u_dut (.*);

   always #4 clock = ~clock;

   // accumulator shadow state
   logic [15:0]                trig_cnt [NCH];
   logic [pcaa_pkg::SUM_W-1:0] pos_sum  [NCH*MAXS];
   logic [pcaa_pkg::LAG_W-1:0] lag_acc  [NCH*MAXS];
   logic [11:0]                dig_buf  [MAXS];
   int unsigned                cur_pos;
   logic                       cur_bad;
   logic [15:0]                tps_reg;
   logic [5:0]                 spd_reg;

   result_word_type expected_words[$];
   int  fails = 0;
   int  cycles = 0;
   bit  quiet = 0;     // no idling in the final part
   int  hold_cycles = 0;

   // work out the words caused by one accepted sample word
   task automatic predict_sample(input logic [9:0] ch, input logic [2:0] g,
                                 input logic [11:0] s);
      int unsigned n, p, base, j, k, tps;
      logic [15:0] cnt;
      result_word_type w;
      n = (spd_reg < 1) ? 1 : (spd_reg > MAXS ? MAXS : spd_reg);
      p = (cur_pos >= n) ? n - 1 : cur_pos;
      dig_buf[p] = s;
      if (g >= pcaa_pkg::GAIN_LIMIT) cur_bad = 1;
      if (p + 1 < n) begin
         cur_pos = (p + 1) & 31;
         return;
      end
      cur_pos = 0;
      if (cur_bad) begin
         cur_bad = 0;
         w = '0;
         w.chan = ch; w.gain = g; w.last = 1; w.bad = 1;
         expected_words.insert(expected_words.size(), w);
         return;
      end
      base = ch * MAXS;
      cnt = trig_cnt[ch] + 16'd1;
      trig_cnt[ch] = cnt;
      if (cnt == 1) begin
         for (j = 0; j < MAXS; j++) begin
            pos_sum[base+j] = '0;
            lag_acc[base+j] = '0;
         end
      end
      for (j = 0; j < n; j++) begin
         pos_sum[base+j] = pos_sum[base+j] + dig_buf[j];
         for (k = j; k < n; k++)
            lag_acc[base+k-j] = lag_acc[base+k-j]
                                + pcaa_pkg::LAG_W'(dig_buf[j]) * dig_buf[k];
      end
      tps = (tps_reg < 1) ? 1 : tps_reg;
      if (cnt < tps) return;
      for (j = 0; j < n; j++) begin
         w.chan = ch; w.gain = g; w.pos = j[4:0];
         w.ssum = pos_sum[base+j]; w.lsum = lag_acc[base+j];
         w.total = cnt; w.last = (j + 1 == n); w.bad = 0;
         expected_words.insert(expected_words.size(), w);
      end
      trig_cnt[ch] = '0;
   endtask

   // send one sample word, with random idling before it
   task automatic send_sample(input logic [9:0] ch, input logic [2:0] g,
                              input logic [11:0] s);
      int gap;
      gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {7'd0, s, g, ch};
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
      predict_sample(ch, g, s);
   endtask

   task automatic wait_drained();
      req_tvalid <= 0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
   endtask

   task automatic write_reg(input int idx, input logic [31:0] val);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= pcaa_pkg::CSR_AW'(idx * 4); csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      if (idx == IDX_TPS) tps_reg = val[15:0];
      else spd_reg = val[5:0];
      @(posedge clock);
   endtask

   task automatic set_config(input logic [15:0] tps, input logic [5:0] spd);
      wait_drained();
      write_reg(IDX_TPS, tps);
      write_reg(IDX_SPD, spd);
   endtask

   task automatic send_digit(input logic [9:0] ch, input logic [2:0] g, input int n);
      for (int i = 0; i < n; i++) send_sample(ch, g, 12'($urandom));
   endtask

   // extremes of the samples, valid and bad gains, a bad gain early in a
   // digit, channel taken from the completing sample
   task automatic test_directed();
      set_config(16'd1, 6'd3);
      send_sample(10'd0, 3'd0, 12'hfff);
      send_sample(10'd0, 3'd0, 12'hfff);
      send_sample(10'd0, 3'd0, 12'hfff);
      send_sample(10'd1023, 3'd1, 12'h000);
      send_sample(10'd1023, 3'd1, 12'h000);
      send_sample(10'd1023, 3'd2, 12'h000);
      send_sample(10'd5, 3'd7, 12'h123);
      send_sample(10'd5, 3'd0, 12'h456);
      send_sample(10'd6, 3'd0, 12'h789);
      send_digit(10'd7, 3'd3, 3);
      send_sample(10'd9, 3'd1, 12'h555);
      send_sample(10'd9, 3'd1, 12'haaa);
      send_sample(10'd8, 3'd2, 12'h5a5);
   endtask

   // zero step and zero sample count act as one; maximum digit length
   task automatic test_config_extremes();
      set_config(16'd0, 6'd0);
      send_sample(10'd100, 3'd0, 12'hfff);
      send_sample(10'd101, 3'd4, 12'h001);
      set_config(16'd2, 6'd63);
      send_digit(10'd200, 3'd0, 32);
      send_digit(10'd200, 3'd1, 32);
      set_config(16'd65535, 6'd1);
      send_digit(10'd300, 3'd0, 1);
      set_config(16'd1, 6'd32);
      send_digit(10'd301, 3'd2, 32);
   endtask

   // a long hold-off on the result side while samples keep coming
   task automatic test_backpressure();
      set_config(16'd1, 6'd2);
      hold_cycles = 3000;
      for (int i = 0; i < 10; i++) send_digit(10'($urandom_range(0, 3)), 3'd0, 2);
   endtask

   // random digits, mostly well formed, channels from a small pool
   task automatic test_random();
      for (int ph = 0; ph < 4; ph++) begin
         set_config(16'($urandom_range(1, 4)), 6'($urandom_range(1, 8)));
         for (int i = 0; i < 25; i++) begin
            if (ph == 3 && i == 12) quiet = 1;
            send_sample(($urandom_range(0, 9) == 0) ? 10'($urandom)
                                                    : 10'($urandom_range(0, 3)),
                        ($urandom_range(0, 9) == 0) ? 3'($urandom_range(3, 7))
                                                    : 3'($urandom_range(0, 2)),
                        12'($urandom));
         end
      end
   endtask

   // result side: random idling, long hold-off on request
   always @(posedge clock) begin
      if (reset) rsp_tready <= 0;
      else if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_tready <= 0;
      end else rsp_tready <= quiet ? 1'b1 : ($urandom_range(0, 3) != 0);
   end

   // compare every accepted word with the oldest expectation
   always @(posedge clock) begin
      result_word_type got, want;
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[9:0], rsp_tdata[12:10], rsp_tdata[17:13], rsp_tdata[45:18],
                rsp_tdata[90:46], rsp_tdata[106:91], rsp_tlast, rsp_tuser};
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $time, got);
            fails <= fails + 1;
         end else begin
            want = expected_words.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch, expected %h, actual %h", $time, want, got);
               fails <= fails + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles >= LIMIT) begin
         $display("per_channel_autocorrelation_accumulator_top regression: fail");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < NCH; i++) trig_cnt[i] = '0;
      cur_pos = 0; cur_bad = 0;
      tps_reg = pcaa_pkg::TPS_RESET; spd_reg = pcaa_pkg::SPD_RESET;
      repeat (10) @(posedge clock);
      reset <= 0;
      // reset defaults first: five-sample digits
      send_digit(10'd42, 3'd0, 5);
      test_directed();
      test_config_extremes();
      test_backpressure();
      test_random();
      wait_drained();
      if (fails == 0 && expected_words.size() == 0)
         $display("per_channel_autocorrelation_accumulator_top regression: pass");
      else
         $display("per_channel_autocorrelation_accumulator_top regression: fail");
      $finish;
   end
endmodule
